// ===== hdl/lru_key_cache_table_defines.svh =====
// ----------------------------------------------------------------------------
// lru_key_cache_table assertion macros
// Property wrappers shared by the cache table RTL; empty under SYNTH.
// ----------------------------------------------------------------------------
`ifndef LRU_KEY_CACHE_TABLE_DEFINES_SVH
`define LRU_KEY_CACHE_TABLE_DEFINES_SVH
`ifndef SYNTH
`define LKC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("lkc assertion failed");
`define LKC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("lkc assertion failed");
`else
`define LKC_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define LKC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== hdl/lkc_pkg.sv =====
// ----------------------------------------------------------------------------
// lkc_pkg
// Shared constants, operation codes and types of the LRU key cache table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lkc_pkg;

	localparam int ENTRIES = 64;
	localparam int IDX_W   = $clog2(ENTRIES);
	localparam int KEY_W   = 64;
	localparam int HND_W   = 32;
	localparam int STAMP_W = 32;

	localparam logic [1:0] OP_LOOKUP = 2'd0;
	localparam logic [1:0] OP_INSERT = 2'd1;
	localparam logic [1:0] OP_REMOVE = 2'd2;
	localparam logic [1:0] OP_CLEAR  = 2'd3;

	typedef struct packed {
		logic [KEY_W-1:0]   key;
		logic [HND_W-1:0]   handle;
		logic [STAMP_W-1:0] stamp;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef struct packed {
		logic             we;
		logic [IDX_W-1:0] waddr;
		entry_t           wdata;
		logic             re;
		logic [IDX_W-1:0] raddr;
	} ram_req_t;

	typedef struct packed {
		logic             hit;
		logic [HND_W-1:0] found_handle;
		logic             stored;
		logic             evicted;
		logic [HND_W-1:0] evicted_handle;
	} res_t;

endpackage

// ===== hdl/lkc_entry_ram.sv =====
// ----------------------------------------------------------------------------
// lkc_entry_ram
// Simple dual-port synchronous RAM with a registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lkc_entry_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== hdl/lkc_ctrl.sv =====
// ----------------------------------------------------------------------------
// lkc_ctrl
// Scan sequencer: holds the valid flags, walks the entry memory once per
// lookup, insert or remove and commits the chosen entry when the result is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "lru_key_cache_table_defines.svh"

module lkc_ctrl (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       req_valid,
	output logic                       req_stall,
	input  logic [1:0]                 operation,
	input  logic [lkc_pkg::KEY_W-1:0]  key_tag,
	input  logic [lkc_pkg::HND_W-1:0]  handle,
	input  logic [lkc_pkg::STAMP_W-1:0] current_frame,
	input  logic                       res_take,
	output logic                       res_valid,
	output lkc_pkg::res_t              res,
	output lkc_pkg::ram_req_t          ram_req,
	input  lkc_pkg::entry_t            ram_rdata
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;
	localparam logic [lkc_pkg::IDX_W-1:0] LAST_IDX = lkc_pkg::IDX_W'(lkc_pkg::ENTRIES - 1);

	logic [1:0]                    state_q;
	logic [lkc_pkg::ENTRIES-1:0]   valid_q;
	logic [1:0]                    op_q;
	logic [lkc_pkg::KEY_W-1:0]     key_q;
	logic [lkc_pkg::HND_W-1:0]     hnd_q;
	logic [lkc_pkg::STAMP_W-1:0]   frame_q;
	logic [lkc_pkg::IDX_W-1:0]     rd_idx_q;
	logic                          issued_all_q;
	logic                          chk_vld_s1;
	logic [lkc_pkg::IDX_W-1:0]     chk_idx_s1;
	logic                          found_q;
	logic                          free_q;
	logic [lkc_pkg::IDX_W-1:0]     slot_q;
	logic [lkc_pkg::HND_W-1:0]     slot_hnd_q;
	logic [lkc_pkg::STAMP_W-1:0]   oldest_q;
	logic                          accept;
	logic                          issue;
	logic                          commit;
	logic                          chk_v;

	assign req_stall = (state_q != ST_IDLE);
	assign accept    = req_valid && !req_stall;
	assign issue     = (state_q == ST_SCAN) && !issued_all_q;
	assign res_valid = (state_q == ST_DONE);
	assign commit    = res_valid && res_take;
	assign chk_v     = valid_q[chk_idx_s1];

	always_comb begin
		res.hit            = (op_q == lkc_pkg::OP_LOOKUP) && found_q;
		res.found_handle   = res.hit ? slot_hnd_q : '0;
		res.stored         = (op_q == lkc_pkg::OP_INSERT) && found_q;
		res.evicted        = res.stored && !free_q;
		res.evicted_handle = res.evicted ? slot_hnd_q : '0;
	end

	always_comb begin
		ram_req.re    = issue;
		ram_req.raddr = rd_idx_q;
		ram_req.waddr = slot_q;
		ram_req.we    = commit && found_q &&
			((op_q == lkc_pkg::OP_LOOKUP) || (op_q == lkc_pkg::OP_INSERT));
		ram_req.wdata.key    = key_q;
		ram_req.wdata.handle = (op_q == lkc_pkg::OP_INSERT) ? hnd_q : slot_hnd_q;
		ram_req.wdata.stamp  = frame_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			valid_q      <= '0;
			issued_all_q <= 1'b0;
			chk_vld_s1   <= 1'b0;
			found_q      <= 1'b0;
			free_q       <= 1'b0;
		end else begin
			chk_vld_s1 <= issue;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						found_q      <= 1'b0;
						free_q       <= 1'b0;
						issued_all_q <= 1'b0;
						if (operation == lkc_pkg::OP_CLEAR) begin
							valid_q <= '0;
							state_q <= ST_DONE;
						end else begin
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					if (issue && (rd_idx_q == LAST_IDX)) begin
						issued_all_q <= 1'b1;
					end
					if (chk_vld_s1) begin
						case (op_q)
							lkc_pkg::OP_LOOKUP: begin
								if (!found_q && chk_v && (ram_rdata.key == key_q)) begin
									found_q <= 1'b1;
								end
							end
							lkc_pkg::OP_INSERT: begin
								if ((hnd_q != '0) && !free_q) begin
									if (!chk_v) begin
										found_q <= 1'b1;
										free_q  <= 1'b1;
									end else if (ram_rdata.stamp < oldest_q) begin
										found_q <= 1'b1;
									end
								end
							end
							lkc_pkg::OP_REMOVE: begin
								if ((hnd_q != '0) && !found_q && chk_v &&
										(ram_rdata.handle == hnd_q)) begin
									found_q <= 1'b1;
								end
							end
							default: begin
							end
						endcase
						if (chk_idx_s1 == LAST_IDX) begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_DONE: begin
					if (commit) begin
						state_q <= ST_IDLE;
						if (found_q && (op_q == lkc_pkg::OP_INSERT)) begin
							valid_q[slot_q] <= 1'b1;
						end
						if (found_q && (op_q == lkc_pkg::OP_REMOVE)) begin
							valid_q[slot_q] <= 1'b0;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		chk_idx_s1 <= rd_idx_q;
		if (accept) begin
			op_q     <= operation;
			key_q    <= key_tag;
			hnd_q    <= handle;
			frame_q  <= current_frame;
			oldest_q <= current_frame;
			rd_idx_q <= '0;
		end else if (issue) begin
			rd_idx_q <= rd_idx_q + 1'b1;
		end
		if ((state_q == ST_SCAN) && chk_vld_s1) begin
			case (op_q)
				lkc_pkg::OP_LOOKUP: begin
					if (!found_q && chk_v && (ram_rdata.key == key_q)) begin
						slot_q     <= chk_idx_s1;
						slot_hnd_q <= ram_rdata.handle;
					end
				end
				lkc_pkg::OP_INSERT: begin
					if ((hnd_q != '0) && !free_q) begin
						if (!chk_v) begin
							slot_q <= chk_idx_s1;
						end else if (ram_rdata.stamp < oldest_q) begin
							slot_q     <= chk_idx_s1;
							slot_hnd_q <= ram_rdata.handle;
							oldest_q   <= ram_rdata.stamp;
						end
					end
				end
				lkc_pkg::OP_REMOVE: begin
					if ((hnd_q != '0) && !found_q && chk_v &&
							(ram_rdata.handle == hnd_q)) begin
						slot_q <= chk_idx_s1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	`LKC_ASSERT_SAME(a_write_outside_scan, clk, arst_n, ram_req.we, !issue && !chk_vld_s1)
	`LKC_ASSERT_SAME(a_evict_needs_store, clk, arst_n, res_valid && res.evicted, res.stored && (hnd_q != '0))
	`LKC_ASSERT_NEXT(a_clear_empties, clk, arst_n, accept && (operation == lkc_pkg::OP_CLEAR), valid_q == '0)
	`LKC_ASSERT_NEXT(a_insert_marks_valid, clk, arst_n, commit && found_q && (op_q == lkc_pkg::OP_INSERT), valid_q[$past(slot_q)])

endmodule

// ===== hdl/lru_key_cache_table.sv =====
// ----------------------------------------------------------------------------
// lru_key_cache_table
// Fully associative key cache with least-recently-used replacement.
// ----------------------------------------------------------------------------
// The table handles one operation at a time and holds req_stall high while
// it works. Lookup, insert and remove each walk every entry of the single
// read port entry memory, one entry per cycle; clear skips the walk. The
// next request is taken once the result has moved into the output register,
// even while that register waits on rsp_stall. Valid flags are cleared
// directly by reset, so there is no clearing pass after reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lru_key_cache_table (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        req_valid,
	output logic                        req_stall,
	input  logic [1:0]                  operation,
	input  logic [lkc_pkg::KEY_W-1:0]   key_tag,
	input  logic [lkc_pkg::HND_W-1:0]   handle,
	input  logic [lkc_pkg::STAMP_W-1:0] current_frame,
	output logic                        rsp_valid,
	input  logic                        rsp_stall,
	output logic                        hit,
	output logic [lkc_pkg::HND_W-1:0]   found_handle,
	output logic                        stored,
	output logic                        evicted,
	output logic [lkc_pkg::HND_W-1:0]   evicted_handle
);

	lkc_pkg::ram_req_t ram_req;
	lkc_pkg::entry_t   ram_rdata;
	lkc_pkg::res_t     res;
	logic              res_valid;
	logic              res_take;
	logic              rsp_valid_q;
	lkc_pkg::res_t     rsp_q;

	assign res_take = !rsp_valid_q || !rsp_stall;

	lkc_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.req_valid     (req_valid),
		.req_stall     (req_stall),
		.operation     (operation),
		.key_tag       (key_tag),
		.handle        (handle),
		.current_frame (current_frame),
		.res_take      (res_take),
		.res_valid     (res_valid),
		.res           (res),
		.ram_req       (ram_req),
		.ram_rdata     (ram_rdata)
	);

	lkc_entry_ram #(
		.WIDTH (lkc_pkg::ENTRY_W),
		.DEPTH (lkc_pkg::ENTRIES)
	) u_entry_ram (
		.clk   (clk),
		.we    (ram_req.we),
		.waddr (ram_req.waddr),
		.wdata (ram_req.wdata),
		.re    (ram_req.re),
		.raddr (ram_req.raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_take) begin
			rsp_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take && res_valid) begin
			rsp_q <= res;
		end
	end

	assign rsp_valid      = rsp_valid_q;
	assign hit            = rsp_q.hit;
	assign found_handle   = rsp_q.found_handle;
	assign stored         = rsp_q.stored;
	assign evicted        = rsp_q.evicted;
	assign evicted_handle = rsp_q.evicted_handle;

endmodule

// ===== bench/tb_lru_key_cache_table.sv =====
// ----------------------------------------------------------------------------
// tb_lru_key_cache_table
// Self-checking bench for the LRU key cache table. A clocked driver feeds
// lookup, insert, remove and clear requests from a queue. A behavioral copy
// of the table predicts each response, and a clocked monitor compares every
// response transfer field by field while both sides idle and stall at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_lru_key_cache_table;

	localparam int CYCLE_LIMIT      = 1_000_000;
	localparam int DRAIN_CYCLES     = 4 * lkc_pkg::ENTRIES + 32;
	localparam int RANDOM_OPS       = 1930;
	localparam int LONG_HOLD_CYCLES = 600;
	localparam int KEY_POOL         = 80;
	localparam int HANDLE_POOL      = 48;
	localparam int MAX_PRINTED      = 100;

	typedef struct {
		logic [1:0]                  op;
		logic [lkc_pkg::KEY_W-1:0]   key;
		logic [lkc_pkg::HND_W-1:0]   hnd;
		logic [lkc_pkg::STAMP_W-1:0] frame;
		int                          gap;
	} cache_op_t;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          req_valid = 1'b0;
	logic                          req_stall;
	logic [1:0]                    operation = lkc_pkg::OP_LOOKUP;
	logic [lkc_pkg::KEY_W-1:0]     key_tag = '0;
	logic [lkc_pkg::HND_W-1:0]     handle = '0;
	logic [lkc_pkg::STAMP_W-1:0]   current_frame = '0;
	logic                          rsp_valid;
	logic                          rsp_stall = 1'b0;
	logic                          hit;
	logic [lkc_pkg::HND_W-1:0]     found_handle;
	logic                          stored;
	logic                          evicted;
	logic [lkc_pkg::HND_W-1:0]     evicted_handle;
	logic                          long_hold = 1'b0;

	cache_op_t                     op_queue[$];
	lkc_pkg::res_t                 pending_results[$];
	cache_op_t                     cur_op;
	lkc_pkg::res_t                 next_result;
	int                            gap_left = 0;
	bit                            gap_armed = 1'b0;
	int                            hold_left = 0;
	int                            results_seen = 0;
	int                            error_count = 0;

	logic                          ent_valid  [lkc_pkg::ENTRIES];
	logic [lkc_pkg::KEY_W-1:0]     ent_key    [lkc_pkg::ENTRIES];
	logic [lkc_pkg::HND_W-1:0]     ent_handle [lkc_pkg::ENTRIES];
	logic [lkc_pkg::STAMP_W-1:0]   ent_stamp  [lkc_pkg::ENTRIES];
	logic [lkc_pkg::KEY_W-1:0]     key_pool    [KEY_POOL];
	logic [lkc_pkg::HND_W-1:0]     handle_pool [HANDLE_POOL];

	lru_key_cache_table dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.req_valid      (req_valid),
		.req_stall      (req_stall),
		.operation      (operation),
		.key_tag        (key_tag),
		.handle         (handle),
		.current_frame  (current_frame),
		.rsp_valid      (rsp_valid),
		.rsp_stall      (rsp_stall),
		.hit            (hit),
		.found_handle   (found_handle),
		.stored         (stored),
		.evicted        (evicted),
		.evicted_handle (evicted_handle)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	function automatic lkc_pkg::res_t apply_cache_op(cache_op_t r);
		lkc_pkg::res_t               res;
		int                          i;
		int                          slot;
		logic [lkc_pkg::STAMP_W-1:0] oldest;
		res = '0;
		case (r.op)
			lkc_pkg::OP_LOOKUP: begin
				for (i = 0; i < lkc_pkg::ENTRIES; i++) begin
					if (ent_valid[i] && ent_key[i] == r.key) begin
						ent_stamp[i] = r.frame;
						res.hit = 1'b1;
						res.found_handle = ent_handle[i];
						break;
					end
				end
			end
			lkc_pkg::OP_INSERT: begin
				if (r.hnd != '0) begin
					slot = -1;
					oldest = r.frame;
					for (i = 0; i < lkc_pkg::ENTRIES; i++) begin
						if (!ent_valid[i]) begin
							slot = i;
							break;
						end
						if (ent_stamp[i] < oldest) begin
							oldest = ent_stamp[i];
							slot = i;
						end
					end
					if (slot >= 0) begin
						if (ent_valid[slot]) begin
							res.evicted = 1'b1;
							res.evicted_handle = ent_handle[slot];
						end
						ent_key[slot] = r.key;
						ent_handle[slot] = r.hnd;
						ent_stamp[slot] = r.frame;
						ent_valid[slot] = 1'b1;
						res.stored = 1'b1;
					end
				end
			end
			lkc_pkg::OP_REMOVE: begin
				if (r.hnd != '0) begin
					for (i = 0; i < lkc_pkg::ENTRIES; i++) begin
						if (ent_valid[i] && ent_handle[i] == r.hnd) begin
							ent_valid[i] = 1'b0;
							break;
						end
					end
				end
			end
			lkc_pkg::OP_CLEAR: begin
				for (i = 0; i < lkc_pkg::ENTRIES; i++) begin
					ent_valid[i] = 1'b0;
				end
			end
			default: begin
			end
		endcase
		return res;
	endfunction

	function automatic void queue_op(logic [1:0] op, logic [lkc_pkg::KEY_W-1:0] key,
			logic [lkc_pkg::HND_W-1:0] hnd, logic [lkc_pkg::STAMP_W-1:0] frame);
		cache_op_t r;
		r.op = op;
		r.key = key;
		r.hnd = hnd;
		r.frame = frame;
		r.gap = ((op_queue.size() / 128) % 4 == 3) ? 0 : $urandom_range(0, 16);
		op_queue.push_back(r);
	endfunction

	function automatic logic [lkc_pkg::KEY_W-1:0] pick_key();
		if ($urandom_range(0, 99) < 85) begin
			return key_pool[$urandom_range(0, KEY_POOL - 1)];
		end
		return {$urandom, $urandom};
	endfunction

	function automatic logic [lkc_pkg::HND_W-1:0] pick_handle();
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < 85) begin
			return handle_pool[$urandom_range(0, HANDLE_POOL - 1)];
		end else if (sel < 90) begin
			return '0;
		end
		return $urandom;
	endfunction

	function automatic logic [lkc_pkg::STAMP_W-1:0] pick_frame(
			logic [lkc_pkg::STAMP_W-1:0] frame_now);
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < 88) begin
			return frame_now;
		end else if (sel < 96) begin
			return frame_now - $urandom_range(1, 3);
		end
		return $urandom;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		error_count++;
		if (error_count <= MAX_PRINTED) begin
			$display("mismatch at response %0d: %s got %h expected %h",
				results_seen, what, got, want);
		end
	endtask

	// Request side: each queued request waits out its own gap, then is held
	// until the transfer happens.
	always @(posedge clk) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
		end else if (!(req_valid && req_stall)) begin
			if (req_valid) begin
				pending_results.push_back(apply_cache_op(cur_op));
			end
			if (!gap_armed && op_queue.size() > 0) begin
				gap_left = op_queue[0].gap;
				gap_armed = 1'b1;
			end
			if (gap_left > 0) begin
				gap_left--;
				req_valid <= 1'b0;
			end else if (op_queue.size() > 0) begin
				cur_op = op_queue.pop_front();
				gap_armed = 1'b0;
				operation <= cur_op.op;
				key_tag <= cur_op.key;
				handle <= cur_op.hnd;
				current_frame <= cur_op.frame;
				req_valid <= 1'b1;
			end else begin
				req_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			rsp_stall <= 1'b0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				if (pending_results.size() == 0) begin
					report_mismatch("response with nothing pending", 32'(hit), 32'd0);
				end else begin
					next_result = pending_results.pop_front();
					if (hit !== next_result.hit)
						report_mismatch("hit", 32'(hit), 32'(next_result.hit));
					if (found_handle !== next_result.found_handle)
						report_mismatch("found_handle", found_handle,
							next_result.found_handle);
					if (stored !== next_result.stored)
						report_mismatch("stored", 32'(stored), 32'(next_result.stored));
					if (evicted !== next_result.evicted)
						report_mismatch("evicted", 32'(evicted), 32'(next_result.evicted));
					if (evicted_handle !== next_result.evicted_handle)
						report_mismatch("evicted_handle", evicted_handle,
							next_result.evicted_handle);
				end
				results_seen++;
				hold_left = ((results_seen / 128) % 4 == 1) ? 0 : $urandom_range(0, 16);
			end else if (hold_left > 0) begin
				hold_left--;
			end
			rsp_stall <= long_hold || hold_left > 0;
		end
	end

	// The response side holds off for long stretches so the table fills its
	// output register and pushes back on requests.
	initial begin
		int threshold;
		for (threshold = 300; threshold <= 1100; threshold += 800) begin
			while (results_seen < threshold) @(posedge clk);
			long_hold <= 1'b1;
			repeat (LONG_HOLD_CYCLES) @(posedge clk);
			long_hold <= 1'b0;
		end
	end

	initial begin
		int cycle_count;
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("[lru_key_cache_table] ERROR");
		$finish;
	end

	initial begin
		int                          i;
		int                          n;
		int                          episode;
		int                          ops_left;
		int                          sel;
		logic [1:0]                  op;
		logic [lkc_pkg::STAMP_W-1:0] frame_now;
		logic [lkc_pkg::KEY_W-1:0]   ones_key;
		logic [lkc_pkg::HND_W-1:0]   ones_hnd;
		logic [lkc_pkg::STAMP_W-1:0] ones_frame;

		ones_key = '1;
		ones_hnd = '1;
		ones_frame = '1;
		for (i = 0; i < lkc_pkg::ENTRIES; i++) begin
			ent_valid[i] = 1'b0;
		end
		for (i = 0; i < KEY_POOL; i++) begin
			key_pool[i] = {$urandom, $urandom};
		end
		key_pool[0] = '0;
		key_pool[1] = ones_key;
		for (i = 0; i < HANDLE_POOL; i++) begin
			handle_pool[i] = $urandom;
			if (handle_pool[i] == '0)
				handle_pool[i] = 1;
		end
		handle_pool[0] = 1;
		handle_pool[1] = ones_hnd;

		// Directed: empty table, ignored requests, extremes, duplicate keys.
		queue_op(lkc_pkg::OP_LOOKUP, '0, '0, '0);
		queue_op(lkc_pkg::OP_REMOVE, '0, '0, '0);
		queue_op(lkc_pkg::OP_REMOVE, '0, 5, 0);
		queue_op(lkc_pkg::OP_INSERT, 1, '0, 3);
		queue_op(lkc_pkg::OP_INSERT, '0, 1, '0);
		queue_op(lkc_pkg::OP_INSERT, ones_key, ones_hnd, ones_frame);
		queue_op(lkc_pkg::OP_INSERT, '0, 2, 5);
		queue_op(lkc_pkg::OP_LOOKUP, '0, '0, 7);
		queue_op(lkc_pkg::OP_LOOKUP, ones_key, '0, ones_frame);
		queue_op(lkc_pkg::OP_REMOVE, '0, 1, 0);
		queue_op(lkc_pkg::OP_LOOKUP, '0, '0, 8);
		queue_op(lkc_pkg::OP_REMOVE, ones_key, '0, ones_frame);
		queue_op(lkc_pkg::OP_LOOKUP, 64'h5555_5555_5555_5555, '0, 9);
		queue_op(lkc_pkg::OP_CLEAR, ones_key, ones_hnd, ones_frame);
		queue_op(lkc_pkg::OP_LOOKUP, ones_key, '0, ones_frame);
		queue_op(lkc_pkg::OP_INSERT, 64'hAAAA_AAAA_AAAA_AAAA, 32'h5555_5555,
			32'hAAAA_AAAA);
		queue_op(lkc_pkg::OP_LOOKUP, 64'hAAAA_AAAA_AAAA_AAAA, '0, '0);
		queue_op(lkc_pkg::OP_REMOVE, '0, 32'h5555_5555, '0);
		queue_op(lkc_pkg::OP_LOOKUP, 64'hAAAA_AAAA_AAAA_AAAA, '0, 32'h5555_5555);
		queue_op(lkc_pkg::OP_CLEAR, '0, '0, '0);

		// Random episodes: each starts from an empty table and runs long enough
		// to fill it, so eviction, dropped inserts and stamp ties all occur.
		n = 0;
		episode = 0;
		while (n < RANDOM_OPS) begin
			case (episode % 3)
				0: frame_now = $urandom;
				1: frame_now = $urandom_range(0, 20);
				default: frame_now = ones_frame - $urandom_range(0, 20);
			endcase
			queue_op(lkc_pkg::OP_CLEAR, pick_key(), pick_handle(), frame_now);
			n++;
			ops_left = $urandom_range(150, 300);
			while (ops_left > 0 && n < RANDOM_OPS) begin
				if ($urandom_range(0, 199) == 0)
					frame_now = $urandom;
				else if ($urandom_range(0, 5) == 0)
					frame_now = frame_now + 1;
				sel = $urandom_range(0, 999);
				if (sel < 500)
					op = lkc_pkg::OP_INSERT;
				else if (sel < 860)
					op = lkc_pkg::OP_LOOKUP;
				else if (sel < 995)
					op = lkc_pkg::OP_REMOVE;
				else
					op = lkc_pkg::OP_CLEAR;
				queue_op(op, pick_key(), pick_handle(), pick_frame(frame_now));
				ops_left--;
				n++;
			end
			episode++;
		end

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		while (op_queue.size() > 0 || req_valid) @(posedge clk);
		while (pending_results.size() > 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (pending_results.size() > 0)
			report_mismatch("responses never seen", pending_results.size(), 32'd0);

		if (error_count == 0) begin
			$display("[lru_key_cache_table] OK");
		end else begin
			$display("[lru_key_cache_table] ERROR");
		end
		$finish;
	end

endmodule
